### rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the sparse-set slot manager
// Field widths, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // parameter defaults
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int INDEX_BITS_DEF  = 10;
  localparam int ID_WIDTH_DEF    = 32;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int ENTITY_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 10;
  localparam int OFF_W      = 18;
  localparam int CNT_OUT_W  = 11;
  localparam int ES_W       = 9;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_ELEMENT_SIZE = 0;
  localparam logic [ES_W-1:0] ES_RESET = ES_W'(1);

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_STALE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // which result the datapath captures
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ABSENT,
    RES_EXIST,
    RES_FULL,
    RES_ADDED,
    RES_STALE,
    RES_FOUND,
    RES_REMOVED
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic lookup;
    logic add;
    logic remove;
    logic move;
    logic clr_step;
    logic mul_data;
    logic load_out;
    res_t res;
  } ssm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic present;
    logic full;
    logic id_match;
    logic count_zero;
    logic clr_done;
    logic out_free;
  } ssm_sts_t;

endpackage

### rtl/ssm_cmd_if.sv
// ----------------------------------------------------------------------------
// ssm_cmd_if: operation request channel
// Valid/ready channel carrying the operation kind and the entity id.
// ----------------------------------------------------------------------------
interface ssm_cmd_if;
  import ssm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ENTITY_W-1:0] entity_id;

  modport source (output valid, output kind, output entity_id, input ready);
  modport sink   (input valid, input kind, input entity_id, output ready);
endinterface

### rtl/ssm_rsp_if.sv
// ----------------------------------------------------------------------------
// ssm_rsp_if: operation result channel
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface ssm_rsp_if;
  import ssm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [OFF_W-1:0]      data_offset;
  logic                  moved;
  logic [OFF_W-1:0]      move_src_offset;
  logic [CNT_OUT_W-1:0]  live_count;

  modport source (output valid, output status, output slot, output data_offset,
                  output moved, output move_src_offset, output live_count,
                  input ready);
  modport sink   (input valid, input status, input slot, input data_offset,
                  input moved, input move_src_offset, input live_count,
                  output ready);
endinterface

### rtl/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl: operation sequencer
// Steps the datapath through clear, lookup, compare, offset and result.
// ----------------------------------------------------------------------------
module ssm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssm_pkg::ssm_sts_t  sts,
  output ssm_pkg::ssm_cmd_t  cmd
);
  import ssm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CMP,
    S_OFFS,
    S_OUT
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.res    = RES_NONE;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_OFFS;
        // sparse entry is back: add and misses decide here, present get/remove go on to compare
        priority if (sts.kind == KIND_ADD) begin
          priority if (sts.present) begin
            cmd.res = RES_EXIST;
          end else if (sts.full) begin
            cmd.res = RES_FULL;
          end else begin
            cmd.res = RES_ADDED;
            cmd.add = 1'b1;
          end
        end else if ((sts.kind == KIND_GET || sts.kind == KIND_REMOVE) && sts.present) begin
          state_next = S_CMP;
        end else begin
          cmd.res = RES_ABSENT;
        end
      end
      S_CMP: begin
        state_next = S_OFFS;
        priority if (!sts.id_match) begin
          cmd.res = RES_STALE;
        end else if (sts.kind == KIND_REMOVE && !sts.count_zero) begin
          cmd.res    = RES_REMOVED;
          cmd.remove = 1'b1;
        end else begin
          cmd.res = RES_FOUND;
        end
      end
      S_OFFS: begin
        // data offset product, and sparse fixup of the moved entity
        cmd.mul_data = 1'b1;
        cmd.move     = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### rtl/ssm_dpath.sv
// ----------------------------------------------------------------------------
// ssm_dpath: sparse/dense stores, entry count, offset multiplier, result reg
// Executes the sequencer commands and reports lookup flags back to it.
// ----------------------------------------------------------------------------
module ssm_dpath #(
  parameter int MAX_ENTRIES = ssm_pkg::MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = ssm_pkg::INDEX_BITS_DEF,
  parameter int ID_WIDTH    = ssm_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssm_pkg::ssm_cmd_t                 cmd,
  output ssm_pkg::ssm_sts_t                 sts,
  input  logic [ssm_pkg::ES_W-1:0]          element_size,
  input  logic [ssm_pkg::KIND_W-1:0]        in_kind,
  input  logic [ssm_pkg::ENTITY_W-1:0]      in_entity_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssm_pkg::STATUS_W-1:0]      out_status,
  output logic [ssm_pkg::SLOT_OUT_W-1:0]    out_slot,
  output logic [ssm_pkg::OFF_W-1:0]         out_data_offset,
  output logic                              out_moved,
  output logic [ssm_pkg::OFF_W-1:0]         out_move_src_offset,
  output logic [ssm_pkg::CNT_OUT_W-1:0]     out_live_count
);
  import ssm_pkg::*;

  localparam int SPARSE_DEPTH = 1 << INDEX_BITS;
  localparam int SLOT_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W       = (SLOT_W + ES_W > OFF_W) ? SLOT_W + ES_W : OFF_W;

  // stores: sparse entry is {valid, slot}
  logic [SLOT_W:0]         sparse_mem [SPARSE_DEPTH];
  logic [ID_WIDTH-1:0]     dense_mem  [MAX_ENTRIES];

  logic [SLOT_W:0]         sp_q;
  logic [ID_WIDTH-1:0]     dn_a;
  logic [ID_WIDTH-1:0]     dn_b;

  logic [KIND_W-1:0]       kind_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic [CNT_W-1:0]        count;
  logic [INDEX_BITS-1:0]   clr_addr;

  logic [STATUS_W-1:0]     status_q;
  logic [SLOT_W-1:0]       rslot_q;
  logic [SLOT_W-1:0]       src_slot_q;
  logic                    moved_q;
  logic [OFF_W-1:0]        off_q;

  logic [ID_WIDTH-1:0]     in_id;
  logic [INDEX_BITS-1:0]   in_idx;
  logic [INDEX_BITS-1:0]   idx_q;
  logic [INDEX_BITS-1:0]   mv_idx;
  logic [SLOT_W-1:0]       sp_slot;
  logic                    sp_valid;
  logic [SLOT_W-1:0]       last_addr;
  logic                    is_last;
  logic                    count_zero;

  logic                    sp_we;
  logic [INDEX_BITS-1:0]   sp_waddr;
  logic [SLOT_W:0]         sp_wdata;
  logic                    dn_we;
  logic [SLOT_W-1:0]       dn_waddr;
  logic [ID_WIDTH-1:0]     dn_wdata;

  logic [SLOT_W-1:0]       mul_a;
  logic [PROD_W-1:0]       prod;

  // index and flag decode
  assign in_id      = ID_WIDTH'(in_entity_id);
  assign in_idx     = INDEX_BITS'(in_id);
  assign idx_q      = INDEX_BITS'(id_q);
  assign mv_idx     = INDEX_BITS'(dn_b);
  assign sp_slot    = sp_q[SLOT_W-1:0];
  assign sp_valid   = sp_q[SLOT_W];
  assign count_zero = (count == '0);
  assign last_addr  = count_zero ? '0 : SLOT_W'(count - 1'b1);
  assign is_last    = (sp_slot == last_addr);

  always_comb begin
    sts            = '0;
    sts.kind       = kind_q;
    sts.present    = sp_valid;
    sts.full       = (count == CNT_W'(MAX_ENTRIES));
    sts.id_match   = (dn_a == id_q);
    sts.count_zero = count_zero;
    sts.clr_done   = &clr_addr;
    sts.out_free   = !out_valid || out_ready;
  end

  // sparse write port select
  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = idx_q;
    sp_wdata = '0;
    priority if (cmd.clr_step) begin
      sp_we    = 1'b1;
      sp_waddr = clr_addr;
    end else if (cmd.add) begin
      sp_we    = 1'b1;
      sp_wdata = {1'b1, count[SLOT_W-1:0]};
    end else if (cmd.remove) begin
      sp_we    = 1'b1;
    end else if (cmd.move && moved_q) begin
      sp_we    = 1'b1;
      sp_waddr = mv_idx;
      sp_wdata = {1'b1, rslot_q};
    end else begin
      sp_we    = 1'b0;
    end
  end

  // dense write port select
  always_comb begin
    dn_we    = 1'b0;
    dn_waddr = count[SLOT_W-1:0];
    dn_wdata = id_q;
    priority if (cmd.add) begin
      dn_we = 1'b1;
    end else if (cmd.remove && !is_last) begin
      dn_we    = 1'b1;
      dn_waddr = sp_slot;
      dn_wdata = dn_b;
    end else begin
      dn_we = 1'b0;
    end
  end

  // sparse table
  always_ff @(posedge clk) begin
    if (sp_we) sparse_mem[sp_waddr] <= sp_wdata;
    if (cmd.accept) sp_q <= sparse_mem[in_idx];
  end

  // dense id store: entity slot and last slot
  always_ff @(posedge clk) begin
    if (dn_we) dense_mem[dn_waddr] <= dn_wdata;
    if (cmd.lookup) begin
      dn_a <= dense_mem[sp_slot];
      dn_b <= dense_mem[last_addr];
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.add) begin
        count <= count + 1'b1;
      end else if (cmd.remove) begin
        count <= count - 1'b1;
      end
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= in_kind;
      id_q   <= in_id;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    unique case (cmd.res)
      RES_NONE: begin
      end
      RES_ABSENT: begin
        status_q   <= ST_MISS;
        rslot_q    <= '0;
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_EXIST: begin
        status_q   <= ST_MISS;
        rslot_q    <= sp_slot;
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_FULL: begin
        status_q   <= ST_FULL;
        rslot_q    <= '0;
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_ADDED: begin
        status_q   <= ST_DONE;
        rslot_q    <= count[SLOT_W-1:0];
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_STALE: begin
        status_q   <= ST_STALE;
        rslot_q    <= sp_slot;
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_FOUND: begin
        status_q   <= ST_DONE;
        rslot_q    <= sp_slot;
        moved_q    <= 1'b0;
        src_slot_q <= '0;
      end
      RES_REMOVED: begin
        status_q   <= ST_DONE;
        rslot_q    <= sp_slot;
        moved_q    <= !is_last;
        src_slot_q <= is_last ? '0 : last_addr;
      end
    endcase
  end

  // shared offset multiplier: data slot first, move source at result load
  assign mul_a = cmd.mul_data ? rslot_q : src_slot_q;
  assign prod  = PROD_W'(mul_a) * PROD_W'(element_size);

  always_ff @(posedge clk) begin
    if (cmd.mul_data) off_q <= OFF_W'(prod);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status          <= status_q;
      out_slot            <= SLOT_OUT_W'(rslot_q);
      out_data_offset     <= off_q;
      out_moved           <= moved_q;
      out_move_src_offset <= OFF_W'(prod);
      out_live_count      <= CNT_OUT_W'(count);
    end
  end

endmodule

### rtl/sparse_set_slot_manager_top.sv
// Flow: add and misses are decided from the sparse read, get and remove after
//   the dense read and id compare; both then go through the offset multiplier.
// Items: one at a time, set by the dependent sparse and dense memory reads and
//   the shared offset multiplier; the next is taken after the result is loaded.
// Reset: synchronous; a clearing pass over all 2^INDEX_BITS sparse entries
//   (1024 by default) empties the table, with ready low, before the first item is taken.
// ----------------------------------------------------------------------------
// sparse_set_slot_manager_top: sparse-set slot manager with swap-remove
// APB element size register, sequencer and datapath, result channel.
// ----------------------------------------------------------------------------
module sparse_set_slot_manager_top #(
  parameter int MAX_ENTRIES = ssm_pkg::MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = ssm_pkg::INDEX_BITS_DEF,
  parameter int ID_WIDTH    = ssm_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ssm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ssm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  ssm_cmd_if.sink                         cmd,
  ssm_rsp_if.source                       rsp
);
  import ssm_pkg::*;

  logic [ES_W-1:0]        element_size;
  logic [APB_ADDR_W-3:0]  reg_idx;
  logic                   reg_hit;
  ssm_cmd_t               ctl_cmd;
  ssm_sts_t               ctl_sts;

  // register decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_hit = (reg_idx == (APB_ADDR_W-2)'(REG_ELEMENT_SIZE));
  assign prdata  = reg_hit ? APB_DATA_W'(element_size) : '0;

  // element size register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_size <= ES_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      element_size <= ES_W'(pwdata);
    end
  end

  // sequencer
  ssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // datapath
  ssm_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (ctl_cmd),
    .sts                 (ctl_sts),
    .element_size        (element_size),
    .in_kind             (cmd.kind),
    .in_entity_id        (cmd.entity_id),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_status          (rsp.status),
    .out_slot            (rsp.slot),
    .out_data_offset     (rsp.data_offset),
    .out_moved           (rsp.moved),
    .out_move_src_offset (rsp.move_src_offset),
    .out_live_count      (rsp.live_count)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("item accepted while another is in flight");

  // full answer only with a full store and slot zero
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |->
      (rsp.live_count == CNT_OUT_W'(MAX_ENTRIES) && rsp.slot == '0))
    else $error("full status with store not full");

  // a move only comes with a completed remove
  a_move_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.moved) |-> (rsp.status == ST_DONE))
    else $error("move reported on a failed operation");

  // no result is offered while the sparse table is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.clr_step |-> (!rsp.valid && !cmd.ready))
    else $error("activity during sparse clearing pass");
`endif

endmodule

### bench/slot_manager_checker.sv
// ----------------------------------------------------------------------------
// slot_manager_checker: result predictor and comparator for the slot manager
// Watches the register port and both item channels, keeps its own sparse
// table, dense id store and live count, and checks every result item.
// ----------------------------------------------------------------------------
module slot_manager_checker #(
  parameter int MAX_ENTRIES = ssm_pkg::MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = ssm_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssm_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [ssm_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           pready,
  ssm_cmd_if                             cmd,
  ssm_rsp_if                             rsp,
  output int                             pending,
  output int                             errors,
  output int                             checked
);
  import ssm_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam logic [APB_ADDR_W-1:0] ES_ADDR = APB_ADDR_W'(REG_ELEMENT_SIZE * 4);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [OFF_W-1:0]      data_offset;
    logic                  moved;
    logic [OFF_W-1:0]      move_src_offset;
    logic [CNT_OUT_W-1:0]  live_count;
  } slot_result_t;

  // shadow of the block state
  bit                  sparse_on [DEPTH];
  int unsigned         sparse_at [DEPTH];
  logic [ENTITY_W-1:0] dense_id  [MAX_ENTRIES];
  int unsigned         live;
  logic [ES_W-1:0]     elem_size;

  slot_result_t due_results [$];
  slot_result_t got, want;

  // byte offset of a slot, wrapped to the offset width
  function automatic logic [OFF_W-1:0] byte_offset_of(int unsigned slot);
    return OFF_W'(slot * elem_size);
  endfunction

  // apply one operation to the shadow state and return its result item
  function automatic slot_result_t resolve_entity_op(logic [KIND_W-1:0] op,
                                                     logic [ENTITY_W-1:0] id);
    int unsigned idx, at, rslot, last, mover;
    slot_result_t r;
    idx   = id & (DEPTH - 1);
    at    = sparse_at[idx];
    rslot = 0;
    r     = '0;
    r.status = ST_MISS;
    if (op == KIND_ADD) begin
      if (sparse_on[idx]) begin
        rslot = at;
      end else if (live >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        rslot           = live;
        sparse_on[idx]  = 1'b1;
        sparse_at[idx]  = live;
        dense_id[live]  = id;
        live++;
        r.status = ST_DONE;
      end
    end else if ((op == KIND_GET || op == KIND_REMOVE) && sparse_on[idx]) begin
      rslot = at;
      if (dense_id[at] !== id) begin
        r.status = ST_STALE;
      end else begin
        r.status = ST_DONE;
        // swap-remove: last dense entry fills the freed slot
        if (op == KIND_REMOVE) begin
          last = live - 1;
          sparse_on[idx] = 1'b0;
          if (at != last) begin
            mover = dense_id[last] & (DEPTH - 1);
            dense_id[at]      = dense_id[last];
            sparse_on[mover]  = 1'b1;
            sparse_at[mover]  = at;
            r.moved           = 1'b1;
            r.move_src_offset = byte_offset_of(last);
          end
          live = last;
        end
      end
    end
    r.slot = SLOT_OUT_W'(rslot);
    if (r.status == ST_FULL || (r.status == ST_MISS && op != KIND_ADD))
      r.data_offset = '0;
    else
      r.data_offset = byte_offset_of(rslot);
    r.live_count = CNT_OUT_W'(live);
    return r;
  endfunction

  // report the first few failures, count all of them
  task automatic flag(string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) sparse_on[i] = 1'b0;
      live      = 0;
      elem_size = ES_RESET;
      due_results.delete();
      pending <= 0;
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr == ES_ADDR) begin
        if (pwrite)
          elem_size = pwdata[ES_W-1:0];
        else if (prdata[ES_W-1:0] !== elem_size)
          flag($sformatf("element_size read expected %0d got %0d",
                         elem_size, prdata[ES_W-1:0]));
      end
      // result item leaves the block
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.slot, rsp.data_offset, rsp.moved,
               rsp.move_src_offset, rsp.live_count};
        if (due_results.size() == 0) begin
          flag("result item with no operation outstanding");
        end else begin
          want = due_results.pop_front();
          checked++;
          if (got !== want)
            flag($sformatf({"result %0d: expected st=%0d slot=%0d off=%0d mv=%0d",
                            " src=%0d live=%0d, got st=%0d slot=%0d off=%0d mv=%0d",
                            " src=%0d live=%0d"}, checked,
                           want.status, want.slot, want.data_offset, want.moved,
                           want.move_src_offset, want.live_count,
                           got.status, got.slot, got.data_offset, got.moved,
                           got.move_src_offset, got.live_count));
        end
      end
      // operation item enters the block
      if (cmd.valid && cmd.ready)
        due_results.push_back(resolve_entity_op(cmd.kind, cmd.entity_id));
      pending <= due_results.size();
    end
  end

endmodule

### bench/tb_sparse_set_slot_manager_top.sv
// ----------------------------------------------------------------------------
// tb_sparse_set_slot_manager_top: stimulus and verdict for the slot manager
// Directed add/get/remove corner cases, a complete fill of the sparse table,
// then mixed random traffic under several element sizes with random stalls
// on both channels; results are checked by slot_manager_checker.
// ----------------------------------------------------------------------------
module tb_sparse_set_slot_manager_top;
  import ssm_pkg::*;

  localparam int DEPTH        = 1 << INDEX_BITS_DEF;
  localparam int GEN_BITS     = ENTITY_W - INDEX_BITS_DEF;
  localparam int LIMIT_CYCLES = 800_000;
  localparam logic [KIND_W-1:0]     KIND_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ES_ADDR = APB_ADDR_W'(REG_ELEMENT_SIZE * 4);

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  logic                  pready;

  ssm_cmd_if cmd_ch ();
  ssm_rsp_if rsp_ch ();

  int pending, errors, checked;

  // stimulus-side view of which ids are live, used to aim gets and removes
  bit                  on_idx [DEPTH];
  logic [ENTITY_W-1:0] id_at  [DEPTH];
  int                  held   [$];

  bit calm;
  int rx_stall;
  int n_kind [4];
  int n_sizes;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sparse_set_slot_manager_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch)
  );

  slot_manager_checker slot_check (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .pending (pending),
    .errors  (errors),
    .checked (checked)
  );

  // idle length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int c;
    if (calm) return 0;
    c = $urandom_range(0, 99);
    if (c < 55) return 0;
    if (c < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial rsp_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      rsp_ch.ready <= 1'b1;
      rx_stall = pick_gap();
    end
  end

  // present one operation item and wait for it to be taken
  task automatic send_op(logic [KIND_W-1:0] op, logic [ENTITY_W-1:0] id);
    int gap, idx;
    int hit [$];
    gap = pick_gap();
    idx = id & (DEPTH - 1);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.kind      <= op;
    cmd_ch.entity_id <= id;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    n_kind[op]++;
    if (op == KIND_ADD && !on_idx[idx] && held.size() < MAX_ENTRIES_DEF) begin
      on_idx[idx] = 1'b1;
      id_at[idx]  = id;
      held.push_back(idx);
    end else if (op == KIND_REMOVE && on_idx[idx] && id_at[idx] == id) begin
      on_idx[idx] = 1'b0;
      hit = held.find_first_index(x) with (x == idx);
      held.delete(hit[0]);
    end
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // one register port transfer, write or read
  task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ES_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // new element size while idle, then read it back
  task automatic set_elem_size(logic [ES_W-1:0] v);
    drain_results();
    apb_access(1'b1, APB_DATA_W'(v));
    apb_access(1'b0, '0);
    n_sizes++;
  endtask

  // mostly a live id, sometimes a stale generation, sometimes anything
  function automatic logic [ENTITY_W-1:0] target_id();
    int c, idx;
    if (held.size() == 0) return $urandom();
    c   = $urandom_range(0, 9);
    idx = held[$urandom_range(0, held.size() - 1)];
    if (c < 7) return id_at[idx];
    if (c < 8)
      return id_at[idx] ^ (ENTITY_W'($urandom_range(1, (1 << GEN_BITS) - 1))
                           << INDEX_BITS_DEF);
    return $urandom();
  endfunction

  // random mix of operations with given add and remove shares
  task automatic run_mixed(int n, int add_pct, int rem_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        if ($urandom_range(0, 9) < 8 || held.size() == 0)
          send_op(KIND_ADD, $urandom());
        else
          send_op(KIND_ADD, id_at[held[$urandom_range(0, held.size() - 1)]]);
      end else if (r < add_pct + rem_pct) begin
        send_op(KIND_REMOVE, target_id());
      end else if (r < 97) begin
        send_op(KIND_GET, target_id());
      end else begin
        send_op(KIND_UNUSED, $urandom());
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  // add one entity for every index, in a scrambled order
  task automatic fill_table();
    int base, idx;
    base = $urandom_range(0, DEPTH - 1);
    for (int i = 0; i < DEPTH; i++) begin
      idx = (base + i * 389) & (DEPTH - 1);
      send_op(KIND_ADD, ($urandom() & ~ENTITY_W'(DEPTH - 1)) | ENTITY_W'(idx));
    end
  endtask

  initial begin
    #(20 * LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.kind      = KIND_ADD;
    cmd_ch.entity_id = '0;
    calm             = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the register
    apb_access(1'b0, '0);

    // directed: misses, unknown kind, extremes, present, stale, moves
    send_op(KIND_GET,    32'h0000_0005);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF);
    send_op(KIND_ADD,    32'h0000_0000);
    send_op(KIND_ADD,    32'hFFFF_FFFF);
    send_op(KIND_ADD,    32'h5555_5400);
    send_op(KIND_ADD,    32'hFFFF_FFFF);
    send_op(KIND_GET,    32'hFFFF_FFFF);
    send_op(KIND_GET,    32'hAAAA_AC00);
    send_op(KIND_REMOVE, 32'h1234_5400);
    send_op(KIND_ADD,    32'hAAAA_A955);
    send_op(KIND_ADD,    32'h5555_56AA);
    send_op(KIND_REMOVE, 32'h0000_0000);
    send_op(KIND_GET,    32'h5555_56AA);
    send_op(KIND_REMOVE, 32'hAAAA_A955);
    send_op(KIND_UNUSED, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF);
    send_op(KIND_REMOVE, 32'h5555_56AA);
    send_op(KIND_GET,    32'h0000_0000);
    set_elem_size(9'd256);
    send_op(KIND_ADD,    32'h8000_0001);
    send_op(KIND_ADD,    32'h7FFF_FFFE);
    send_op(KIND_REMOVE, 32'h8000_0001);

    // full table, widest size field, then traffic around the full point
    set_elem_size(9'd511);
    fill_table();
    run_mixed(60, 30, 30);

    // random phases under several sizes, one without any idling
    set_elem_size(9'd0);
    run_mixed(200, 20, 55);
    set_elem_size(9'd256);
    calm = 1'b1;
    run_mixed(200, 45, 25);
    calm = 1'b0;
    set_elem_size(ES_W'($urandom_range(2, 255)));
    run_mixed(200, 35, 35);
    set_elem_size(9'd1);
    run_mixed(200, 40, 30);

    drain_results();
    repeat (10) @(negedge clk);

    $display("sent %0d add, %0d get, %0d remove and %0d unknown-kind items",
             n_kind[KIND_ADD], n_kind[KIND_GET], n_kind[KIND_REMOVE],
             n_kind[KIND_UNUSED]);
    $display("%0d element size settings incl. 0, 1, 256, 511; full table; %0d results checked",
             n_sizes, checked);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/ssm_pkg.sv
rtl/ssm_cmd_if.sv
rtl/ssm_rsp_if.sv
rtl/ssm_ctrl.sv
rtl/ssm_dpath.sv
rtl/sparse_set_slot_manager_top.sv
bench/slot_manager_checker.sv
bench/tb_sparse_set_slot_manager_top.sv
